FILE: src/smcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smcr_pkg
// Shared types, constants and reply text for the serial memory command
// responder.
// ----------------------------------------------------------------------------
package smcr_pkg;

	localparam int DEF_MEMORY_BYTES = 1024;
	localparam int ADDR_MAX_W       = 16;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_WINDOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_LONG  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_SHORT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_ADDR_A   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_ADDR_B   = 3'd5;

	localparam logic [15:0] RST_STARTUP_WINDOW = 16'd6000;
	localparam logic [7:0]  RST_COOLDOWN_LONG  = 8'd10;
	localparam logic [7:0]  RST_COOLDOWN_SHORT = 8'd5;
	localparam logic [7:0]  RST_BLOCK_LIMIT    = 8'd50;
	localparam logic [9:0]  RST_FIXED_ADDR_A   = 10'h330;
	localparam logic [9:0]  RST_FIXED_ADDR_B   = 10'h334;

	// request and command bytes
	localparam logic [7:0] REQ_PROG    = 8'd250;
	localparam logic [7:0] REQ_FIXED_A = 8'd254;
	localparam logic [7:0] REQ_FIXED_B = 8'd255;
	localparam logic [7:0] CHR_P       = 8'h50;
	localparam logic [7:0] CHR_W       = 8'h57;
	localparam logic [7:0] CHR_R       = 8'h52;
	localparam logic [7:0] CHR_X       = 8'h58;
	localparam logic [7:0] BYTE_BAD    = 8'hFE;

	// reply byte sources
	localparam logic [1:0] SRC_MEM  = 2'd0;
	localparam logic [1:0] SRC_ZERO = 2'd1;
	localparam logic [1:0] SRC_TEXT = 2'd2;
	localparam logic [1:0] SRC_BAD  = 2'd3;

	// reply texts
	localparam logic [1:0] TXT_PROG = 2'd0;
	localparam logic [1:0] TXT_OK   = 2'd1;
	localparam logic [1:0] TXT_ER   = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [15:0] startup_window_ticks;
		logic [7:0]  cooldown_long;
		logic [7:0]  cooldown_short;
		logic [7:0]  block_count_limit;
		logic [9:0]  fixed_address_a;
		logic [9:0]  fixed_address_b;
	} cfg_t;

	typedef struct packed {
		logic                  we;
		logic [ADDR_MAX_W-1:0] waddr;
		logic [7:0]            wdata;
		logic                  re;
		logic [ADDR_MAX_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} emit_t;

	function automatic logic [7:0] text_char(input logic [1:0] txt, input logic [1:0] idx);
		logic [7:0] c;
		c = 8'h00;
		case (txt)
			TXT_PROG: begin
				case (idx)
					2'd0:    c = 8'h50;
					2'd1:    c = 8'h52;
					2'd2:    c = 8'h4F;
					default: c = 8'h47;
				endcase
			end
			TXT_OK: begin
				c = (idx == 2'd0) ? 8'h4F : 8'h4B;
			end
			default: begin
				c = (idx == 2'd0) ? 8'h45 : 8'h52;
			end
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: src/serial_memory_command_responder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_memory_command_responder_unit
// Byte-stream command responder with a byte store and startup, normal and
// programming modes.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (in_valid/in_stall/in_item) are poll ticks or received bytes.
//   Output items (out_valid/out_stall/out_item) are reply bytes; last marks
//   the final byte of one reply. Replies are 0, 1, 2 or 4 bytes long.
//   One item at a time: acceptance, a decode state, then for each reply
//   byte a store read state and an output load state (which waits while
//   the output is stalled), through a single address adder/compare. The
//   one-entry output register lets the last byte wait while the next item
//   is accepted. After reset the store is cleared one entry per cycle, with
//   in_stall held high; configuration writes are taken anyway. A stalled
//   output holds its item and the sequencer waits with it. Configuration
//   (cfg_we/cfg_index/cfg_data) must be written while idle; the block
//   itself does not enforce this.
// ----------------------------------------------------------------------------
module serial_memory_command_responder_unit #(
	parameter int MEMORY_BYTES = smcr_pkg::DEF_MEMORY_BYTES
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [smcr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [smcr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire smcr_pkg::in_item_t              in_item,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output smcr_pkg::out_item_t                  out_item
);

	smcr_pkg::cfg_t      cfg_q;
	smcr_pkg::out_item_t out_q;
	logic                out_valid_q;
	logic                out_free;
	logic                seq_rdy;
	logic                clr_busy;
	logic [7:0]          rdata;
	smcr_pkg::emit_t     emit;
	smcr_pkg::mem_req_t  req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.startup_window_ticks <= smcr_pkg::RST_STARTUP_WINDOW;
			cfg_q.cooldown_long        <= smcr_pkg::RST_COOLDOWN_LONG;
			cfg_q.cooldown_short       <= smcr_pkg::RST_COOLDOWN_SHORT;
			cfg_q.block_count_limit    <= smcr_pkg::RST_BLOCK_LIMIT;
			cfg_q.fixed_address_a      <= smcr_pkg::RST_FIXED_ADDR_A;
			cfg_q.fixed_address_b      <= smcr_pkg::RST_FIXED_ADDR_B;
		end else if (cfg_we) begin
			case (cfg_index)
				smcr_pkg::CFG_STARTUP_WINDOW: cfg_q.startup_window_ticks <= cfg_data;
				smcr_pkg::CFG_COOLDOWN_LONG:  cfg_q.cooldown_long        <= cfg_data[7:0];
				smcr_pkg::CFG_COOLDOWN_SHORT: cfg_q.cooldown_short       <= cfg_data[7:0];
				smcr_pkg::CFG_BLOCK_LIMIT:    cfg_q.block_count_limit    <= cfg_data[7:0];
				smcr_pkg::CFG_FIXED_ADDR_A:   cfg_q.fixed_address_a      <= cfg_data[9:0];
				smcr_pkg::CFG_FIXED_ADDR_B:   cfg_q.fixed_address_b      <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	smcr_store #(
		.MEMORY_BYTES(MEMORY_BYTES)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rdata    (rdata),
		.clr_busy (clr_busy)
	);

	smcr_seq #(
		.MEMORY_BYTES(MEMORY_BYTES)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_item  (in_item),
		.ready    (seq_rdy),
		.clr_busy (clr_busy),
		.out_free (out_free),
		.emit     (emit),
		.req      (req),
		.rdata    (rdata)
	);

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_q <= emit.item;
		end
	end

	assign in_stall  = !seq_rdy;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> out_free)
		else $error("reply byte loaded while output register still held");

	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req.we |-> !clr_busy)
		else $error("store write during clearing sweep");

	a_idle_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		seq_rdy |-> !emit.valid)
		else $error("reply byte emitted while sequencer idle");
`endif

endmodule
`default_nettype wire

FILE: src/smcr_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smcr_store
// Byte store with one write and one registered read port, and a clearing
// sweep after reset that zeroes one entry per cycle.
// ----------------------------------------------------------------------------
module smcr_store #(
	parameter int MEMORY_BYTES = smcr_pkg::DEF_MEMORY_BYTES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire smcr_pkg::mem_req_t req,
	output logic [7:0]              rdata,
	output logic                    clr_busy
);

	localparam int AW = $clog2(MEMORY_BYTES);

	logic [7:0]    mem [MEMORY_BYTES];
	logic [AW-1:0] clr_idx_q;
	logic          clr_busy_q;
	logic [7:0]    rdata_q;
	logic          wen;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;

	always_comb begin
		wen   = clr_busy_q | req.we;
		waddr = clr_busy_q ? clr_idx_q : req.waddr[AW-1:0];
		wdata = clr_busy_q ? 8'h00 : req.wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			if (clr_idx_q == AW'(MEMORY_BYTES - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr[AW-1:0]];
		end
	end

	assign rdata    = rdata_q;
	assign clr_busy = clr_busy_q;

endmodule
`default_nettype wire

FILE: src/smcr_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smcr_seq
// Command sequencer: decodes one item, updates mode and parser state, and
// steps through the reply bytes with one shared address adder/compare.
// ----------------------------------------------------------------------------
module smcr_seq #(
	parameter int MEMORY_BYTES = smcr_pkg::DEF_MEMORY_BYTES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire smcr_pkg::cfg_t     cfg,
	input  wire logic               in_valid,
	input  wire smcr_pkg::in_item_t in_item,
	output logic                    ready,
	input  wire logic               clr_busy,
	input  wire logic               out_free,
	output smcr_pkg::emit_t         emit,
	output smcr_pkg::mem_req_t      req,
	input  wire logic [7:0]         rdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DEC  = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_WR   = 2'd3;

	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_NORM  = 2'd1;
	localparam logic [1:0] MODE_PROG  = 2'd2;

	localparam logic [1:0] STEP_CMD  = 2'd0;
	localparam logic [1:0] STEP_HI   = 2'd1;
	localparam logic [1:0] STEP_LO   = 2'd2;
	localparam logic [1:0] STEP_DATA = 2'd3;

	localparam logic [16:0] MEM_LIMIT = 17'(MEMORY_BYTES);

	logic [1:0]         state_q;
	smcr_pkg::in_item_t item_q;
	logic [1:0]         mode_q;
	logic [15:0]        scnt_q;
	logic [7:0]         cd_q;
	logic [1:0]         step_q;
	logic               pend_q;
	logic [7:0]         hi_q;
	logic [7:0]         lo_q;
	logic [15:0]        base_q;
	logic [1:0]         src_q;
	logic [1:0]         txt_q;
	logic [1:0]         idx_q;
	logic [1:0]         n_q;

	logic [1:0]  eff_mode;
	logic [15:0] scnt_inc;
	logic [7:0]  b;
	logic [15:0] prog_addr;
	logic [15:0] a_dec;
	logic [1:0]  off_dec;
	logic [15:0] op_a;
	logic [1:0]  op_b;
	logic [16:0] sum;
	logic        inr;

	logic [1:0]  mode_d;
	logic [15:0] scnt_d;
	logic [7:0]  cd_d;
	logic [1:0]  step_d;
	logic        pend_d;
	logic [7:0]  hi_d;
	logic [7:0]  lo_d;
	logic        reply;
	logic [1:0]  src_d;
	logic [1:0]  txt_d;
	logic [1:0]  n_d;
	logic        we_d;
	logic [7:0]  byte_out;

	assign b         = item_q.rx_byte;
	assign eff_mode  = (mode_q == MODE_START && scnt_q >= cfg.startup_window_ticks) ?
		MODE_NORM : mode_q;
	assign scnt_inc  = (scnt_q == 16'hFFFF) ? scnt_q : scnt_q + 16'd1;
	assign prog_addr = (step_q == STEP_LO) ? {hi_q, b} : {hi_q, lo_q};

	always_comb begin
		if (eff_mode == MODE_PROG) begin
			a_dec   = prog_addr;
			off_dec = 2'd0;
		end else if (b == smcr_pkg::REQ_FIXED_A) begin
			a_dec   = {6'd0, cfg.fixed_address_a};
			off_dec = 2'd3;
		end else if (b == smcr_pkg::REQ_FIXED_B) begin
			a_dec   = {6'd0, cfg.fixed_address_b};
			off_dec = 2'd3;
		end else begin
			a_dec   = {6'd0, b - 8'd1, 2'b00};
			off_dec = 2'd3;
		end
	end

	// shared address unit: base + offset, range check against the store size
	assign op_a = (state_q == ST_DEC) ? a_dec : base_q;
	assign op_b = (state_q == ST_DEC) ? off_dec : idx_q;
	assign sum  = {1'b0, op_a} + {15'd0, op_b};
	assign inr  = sum < MEM_LIMIT;

	always_comb begin
		mode_d = eff_mode;
		scnt_d = scnt_q;
		cd_d   = cd_q;
		step_d = step_q;
		pend_d = pend_q;
		hi_d   = hi_q;
		lo_d   = lo_q;
		reply  = 1'b0;
		src_d  = smcr_pkg::SRC_TEXT;
		txt_d  = smcr_pkg::TXT_ER;
		n_d    = 2'd0;
		we_d   = 1'b0;
		case (eff_mode)
			MODE_START: begin
				if (!item_q.kind) begin
					scnt_d = scnt_inc;
					if (scnt_inc >= cfg.startup_window_ticks) begin
						mode_d = MODE_NORM;
					end
				end else if (b == smcr_pkg::CHR_P) begin
					mode_d = MODE_PROG;
					step_d = STEP_CMD;
					reply  = 1'b1;
					txt_d  = smcr_pkg::TXT_PROG;
					n_d    = 2'd3;
				end
			end
			MODE_PROG: begin
				if (item_q.kind) begin
					case (step_q)
						STEP_CMD: begin
							if (b == smcr_pkg::CHR_W || b == smcr_pkg::CHR_R) begin
								pend_d = (b == smcr_pkg::CHR_W);
								step_d = STEP_HI;
							end else if (b == smcr_pkg::CHR_X) begin
								mode_d = MODE_NORM;
								reply  = 1'b1;
								txt_d  = smcr_pkg::TXT_OK;
								n_d    = 2'd1;
							end else begin
								reply = 1'b1;
								n_d   = 2'd1;
							end
						end
						STEP_HI: begin
							hi_d   = b;
							step_d = STEP_LO;
						end
						STEP_LO: begin
							lo_d   = b;
							step_d = pend_q ? STEP_DATA : STEP_CMD;
							if (!pend_q) begin
								reply = 1'b1;
								src_d = inr ? smcr_pkg::SRC_MEM : smcr_pkg::SRC_BAD;
							end
						end
						default: begin
							step_d = STEP_CMD;
							reply  = 1'b1;
							n_d    = 2'd1;
							if (inr) begin
								we_d  = 1'b1;
								txt_d = smcr_pkg::TXT_OK;
							end
						end
					endcase
				end
			end
			default: begin
				if (!item_q.kind) begin
					if (cd_q != 8'd0) begin
						cd_d = cd_q - 8'd1;
					end
				end else if (cd_q == 8'd0) begin
					reply = 1'b1;
					n_d   = 2'd3;
					if (b == smcr_pkg::REQ_PROG) begin
						mode_d = MODE_PROG;
						step_d = STEP_CMD;
						cd_d   = cfg.cooldown_long;
						txt_d  = smcr_pkg::TXT_PROG;
					end else if (b == smcr_pkg::REQ_FIXED_A || b == smcr_pkg::REQ_FIXED_B) begin
						src_d = inr ? smcr_pkg::SRC_MEM : smcr_pkg::SRC_ZERO;
						cd_d  = inr ? cfg.cooldown_long : cfg.cooldown_short;
					end else if (b >= 8'd1 && b <= cfg.block_count_limit) begin
						cd_d = inr ? cfg.cooldown_long : cfg.cooldown_short;
						if (inr) begin
							src_d = smcr_pkg::SRC_MEM;
						end else begin
							n_d = 2'd1;
						end
					end else begin
						src_d = smcr_pkg::SRC_ZERO;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_START;
			scnt_q  <= '0;
			cd_q    <= '0;
			step_q  <= STEP_CMD;
			pend_q  <= 1'b0;
			hi_q    <= '0;
			lo_q    <= '0;
			idx_q   <= '0;
			n_q     <= '0;
			src_q   <= smcr_pkg::SRC_ZERO;
			txt_q   <= smcr_pkg::TXT_ER;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && ready) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					mode_q <= mode_d;
					scnt_q <= scnt_d;
					cd_q   <= cd_d;
					step_q <= step_d;
					pend_q <= pend_d;
					hi_q   <= hi_d;
					lo_q   <= lo_d;
					idx_q  <= '0;
					n_q    <= n_d;
					src_q  <= src_d;
					txt_q  <= txt_d;
					state_q <= reply ? ST_RD : ST_IDLE;
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				default: begin
					if (out_free) begin
						if (idx_q == n_q) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= ST_RD;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && ready) begin
			item_q <= in_item;
		end
		if (state_q == ST_DEC) begin
			base_q <= a_dec;
		end
	end

	always_comb begin
		case (src_q)
			smcr_pkg::SRC_MEM:  byte_out = rdata;
			smcr_pkg::SRC_ZERO: byte_out = 8'h00;
			smcr_pkg::SRC_BAD:  byte_out = smcr_pkg::BYTE_BAD;
			default:            byte_out = smcr_pkg::text_char(txt_q, idx_q);
		endcase
	end

	assign ready = (state_q == ST_IDLE) && !clr_busy;

	assign emit.valid        = (state_q == ST_WR) && out_free;
	assign emit.item.tx_byte = byte_out;
	assign emit.item.last    = (idx_q == n_q);

	assign req.we    = (state_q == ST_DEC) && we_d;
	assign req.waddr = prog_addr;
	assign req.wdata = b;
	assign req.re    = (state_q == ST_RD) && (src_q == smcr_pkg::SRC_MEM);
	assign req.raddr = sum[15:0];

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial memory command responder: a clocked
// driver feeds poll ticks and received bytes from a backlog, a clocked monitor
// checks every reply byte against a behavioral copy of the responder (modes,
// cooldown, command parser and byte store), with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
	import smcr_pkg::*;

	localparam int MEM_BYTES     = DEF_MEMORY_BYTES;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam logic [7:0] CHR_A = 8'h41;
	localparam logic [7:0] CHR_B = 8'h42;

	typedef enum logic [1:0] {MODE_STARTUP, MODE_RUN, MODE_PROG} mode_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;

	serial_memory_command_responder_unit #(
		.MEMORY_BYTES(MEM_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// responder copy
	cfg_t regs;
	mode_e mode_now;
	logic [15:0] ticks_seen;
	logic [7:0] cool;
	logic [1:0] parse_at;
	logic pend_write;
	logic [7:0] addr_hi;
	logic [7:0] addr_lo;
	logic [7:0] store_copy [MEM_BYTES];

	in_item_t item_backlog [$];
	out_item_t reply_due [$];
	int mismatches = 0;
	int unsigned planned = 0;
	bit plan_prog = 1'b0;
	logic [7:0] last_hi = 8'd0;
	logic [7:0] last_lo = 8'd0;

	logic tx_calm = 1'b0;
	logic rx_calm = 1'b0;
	logic hold_arm = 1'b0;
	int hold_left = 0;

	task automatic flag(input string what);
		mismatches++;
		$display("tb: mismatch %0d at %0t ns: %s", mismatches, $time, what);
	endtask

	task automatic model_reset();
		regs.startup_window_ticks = RST_STARTUP_WINDOW;
		regs.cooldown_long = RST_COOLDOWN_LONG;
		regs.cooldown_short = RST_COOLDOWN_SHORT;
		regs.block_count_limit = RST_BLOCK_LIMIT;
		regs.fixed_address_a = RST_FIXED_ADDR_A;
		regs.fixed_address_b = RST_FIXED_ADDR_B;
		mode_now = MODE_STARTUP;
		ticks_seen = 16'd0;
		cool = 8'd0;
		parse_at = 2'd0;
		pend_write = 1'b0;
		addr_hi = 8'd0;
		addr_lo = 8'd0;
		for (int i = 0; i < MEM_BYTES; i++)
			store_copy[i] = 8'd0;
	endtask

	task automatic push_reply(input logic [7:0] v, input logic fin);
		out_item_t r;
		r.tx_byte = v;
		r.last = fin;
		reply_due.push_back(r);
	endtask

	task automatic say(input string s);
		for (int i = 0; i < s.len(); i++)
			push_reply(s[i], i == s.len() - 1);
	endtask

	task automatic four_from(input int a, input bit zeros);
		logic [7:0] v;
		for (int i = 0; i < 4; i++) begin
			v = 8'd0;
			if (!zeros && a + i < MEM_BYTES)
				v = store_copy[a + i];
			push_reply(v, i == 3);
		end
	endtask

	task automatic serve(input int a, input bit er_if_out);
		if (a + 3 < MEM_BYTES) begin
			cool = regs.cooldown_long;
			four_from(a, 1'b0);
		end else begin
			cool = regs.cooldown_short;
			if (er_if_out)
				say("ER");
			else
				four_from(0, 1'b1);
		end
	endtask

	task automatic prog_byte(input logic [7:0] b);
		int a;
		a = {addr_hi, addr_lo};
		case (parse_at)
			2'd0: begin
				if (b == CHR_W || b == CHR_R) begin
					pend_write = (b == CHR_W);
					parse_at = 2'd1;
				end else if (b == CHR_X) begin
					mode_now = MODE_RUN;
					say("OK");
				end else begin
					say("ER");
				end
			end
			2'd1: begin
				addr_hi = b;
				parse_at = 2'd2;
			end
			2'd2: begin
				addr_lo = b;
				a = {addr_hi, addr_lo};
				if (pend_write) begin
					parse_at = 2'd3;
				end else begin
					parse_at = 2'd0;
					push_reply((a < MEM_BYTES) ? store_copy[a] : BYTE_BAD, 1'b1);
				end
			end
			default: begin
				parse_at = 2'd0;
				if (a < MEM_BYTES) begin
					store_copy[a] = b;
					say("OK");
				end else begin
					say("ER");
				end
			end
		endcase
	endtask

	task automatic normal_byte(input logic [7:0] b);
		if (cool != 8'd0)
			return;
		if (b == REQ_PROG) begin
			mode_now = MODE_PROG;
			parse_at = 2'd0;
			cool = regs.cooldown_long;
			say("PROG");
		end else if (b == REQ_FIXED_A) begin
			serve(regs.fixed_address_a, 1'b0);
		end else if (b == REQ_FIXED_B) begin
			serve(regs.fixed_address_b, 1'b0);
		end else if (b >= 8'd1 && b <= regs.block_count_limit) begin
			serve((b - 1) * 4, 1'b1);
		end else begin
			four_from(0, 1'b1);
		end
	endtask

	// expected reply bytes for one accepted item
	task automatic respond(input in_item_t it);
		if (mode_now == MODE_STARTUP && ticks_seen >= regs.startup_window_ticks)
			mode_now = MODE_RUN;
		case (mode_now)
			MODE_STARTUP: begin
				if (!it.kind) begin
					if (ticks_seen != 16'hFFFF)
						ticks_seen++;
					if (ticks_seen >= regs.startup_window_ticks)
						mode_now = MODE_RUN;
				end else if (it.rx_byte == CHR_P) begin
					mode_now = MODE_PROG;
					parse_at = 2'd0;
					say("PROG");
				end
			end
			MODE_PROG: begin
				if (it.kind)
					prog_byte(it.rx_byte);
			end
			default: begin
				if (!it.kind) begin
					if (cool != 8'd0)
						cool--;
				end else begin
					normal_byte(it.rx_byte);
				end
			end
		endcase
	endtask

	task automatic check_reply(input out_item_t got);
		out_item_t want;
		if (reply_due.size() == 0) begin
			flag($sformatf("unexpected byte %02h last %0b", got.tx_byte, got.last));
		end else begin
			want = reply_due.pop_front();
			if (got.tx_byte !== want.tx_byte)
				flag($sformatf("tx_byte %02h, want %02h", got.tx_byte, want.tx_byte));
			if (got.last !== want.last)
				flag($sformatf("last %0b, want %0b", got.last, want.last));
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				respond(in_item);
			if (!in_valid || !in_stall) begin
				if (item_backlog.size() != 0 && (tx_calm || $urandom_range(0, 99) >= 25)) begin
					in_valid <= 1'b1;
					in_item <= item_backlog.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_reply(out_item);
		out_stall <= (hold_left != 0) || (!rx_calm && $urandom_range(0, 99) < 25);
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (hold_arm)
			hold_left <= HOLD_CYCLES;
	end

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[15:0];
		case (idx)
			CFG_STARTUP_WINDOW: regs.startup_window_ticks = val[15:0];
			CFG_COOLDOWN_LONG:  regs.cooldown_long = val[7:0];
			CFG_COOLDOWN_SHORT: regs.cooldown_short = val[7:0];
			CFG_BLOCK_LIMIT:    regs.block_count_limit = val[7:0];
			CFG_FIXED_ADDR_A:   regs.fixed_address_a = val[9:0];
			CFG_FIXED_ADDR_B:   regs.fixed_address_b = val[9:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_regs(input int unsigned win, input int unsigned lng,
			input int unsigned shrt, input int unsigned lim,
			input int unsigned fa, input int unsigned fb);
		set_reg(CFG_STARTUP_WINDOW, win);
		set_reg(CFG_COOLDOWN_LONG, lng);
		set_reg(CFG_COOLDOWN_SHORT, shrt);
		set_reg(CFG_BLOCK_LIMIT, lim);
		set_reg(CFG_FIXED_ADDR_A, fa);
		set_reg(CFG_FIXED_ADDR_B, fb);
		@(negedge clk);
	endtask

	function automatic int unsigned pick_addr();
		if ($urandom_range(0, 9) < 3)
			return $urandom_range(1016, 1023);
		return $urandom_range(0, 1023);
	endfunction

	task automatic random_regs();
		write_regs($urandom_range(0, 65535), $urandom_range(0, 4), $urandom_range(0, 4),
			$urandom_range(1, 255), pick_addr(), pick_addr());
	endtask

	task automatic put_byte(input logic [7:0] b);
		in_item_t it;
		it.kind = 1'b1;
		it.rx_byte = b;
		item_backlog.push_back(it);
		planned++;
	endtask

	task automatic put_ticks(input int n);
		in_item_t it;
		for (int i = 0; i < n; i++) begin
			it.kind = 1'b0;
			it.rx_byte = 8'($urandom);
			item_backlog.push_back(it);
			planned++;
		end
	endtask

	task automatic maybe_tick();
		if ($urandom_range(0, 9) == 0)
			put_ticks(1);
	endtask

	task automatic prog_command();
		int r;
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		hi = 8'($urandom_range(0, 3));
		if ($urandom_range(0, 9) == 0)
			hi = 8'($urandom);
		lo = 8'($urandom);
		if (r < 45) begin
			put_byte(CHR_W);
			maybe_tick();
			put_byte(hi);
			put_byte(lo);
			maybe_tick();
			put_byte(8'($urandom));
			last_hi = hi;
			last_lo = lo;
		end else if (r < 85) begin
			if ($urandom_range(0, 1) == 0) begin
				hi = last_hi;
				lo = last_lo;
			end
			put_byte(CHR_R);
			put_byte(hi);
			maybe_tick();
			put_byte(lo);
		end else begin
			b = 8'($urandom);
			if (b == CHR_W || b == CHR_R || b == CHR_X)
				b = CHR_B;
			put_byte(b);
		end
	endtask

	task automatic normal_request();
		int unsigned full;
		bit drained;
		int r;
		logic [7:0] b;
		full = (regs.cooldown_long > regs.cooldown_short) ? regs.cooldown_long
			: regs.cooldown_short;
		drained = ($urandom_range(0, 9) != 0);
		put_ticks(drained ? full : $urandom_range(0, full));
		r = $urandom_range(0, 99);
		if (r < 10)
			b = REQ_PROG;
		else if (r < 20)
			b = REQ_FIXED_A;
		else if (r < 30)
			b = REQ_FIXED_B;
		else if (r < 75)
			b = 8'($urandom_range(1, regs.block_count_limit));
		else if (r < 85 && regs.block_count_limit != 8'd255 && $urandom_range(0, 2) != 0)
			b = 8'($urandom_range(regs.block_count_limit + 1, 255));
		else if (r < 85)
			b = 8'd0;
		else
			b = 8'($urandom);
		// a dropped entry request would leave the mode unknown
		if (b == REQ_PROG && !drained)
			b = 8'd0;
		if (b == REQ_PROG)
			plan_prog = 1'b1;
		put_byte(b);
	endtask

	// leave programming mode and run out the cooldown; called while idle
	task automatic begin_phase();
		if (mode_now == MODE_PROG)
			put_byte(CHR_X);
		put_ticks(cool);
		plan_prog = 1'b0;
	endtask

	task automatic random_items(input int n);
		int unsigned stop;
		stop = planned + n;
		while (planned < stop) begin
			if (plan_prog) begin
				if ($urandom_range(0, 9) == 0) begin
					put_byte(CHR_X);
					plan_prog = 1'b0;
				end else begin
					prog_command();
				end
			end else begin
				normal_request();
			end
		end
	endtask

	task automatic settle();
		int guard;
		guard = 0;
		@(negedge clk);
		while ((item_backlog.size() != 0 || in_valid || reply_due.size() != 0)
				&& guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		if (reply_due.size() != 0) begin
			flag($sformatf("%0d reply bytes never arrived", reply_due.size()));
			reply_due.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int path;
		int cd;
		model_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// startup: window zero, window run out by ticks, or entry with 'P'
		path = $urandom_range(0, 2);
		case (path)
			0: begin
				write_regs(0, RST_COOLDOWN_LONG, RST_COOLDOWN_SHORT, RST_BLOCK_LIMIT,
					RST_FIXED_ADDR_A, RST_FIXED_ADDR_B);
				put_byte(CHR_P);
				put_byte(REQ_PROG);
			end
			1: begin
				write_regs(2, RST_COOLDOWN_LONG, RST_COOLDOWN_SHORT, RST_BLOCK_LIMIT,
					RST_FIXED_ADDR_A, RST_FIXED_ADDR_B);
				put_byte(CHR_A);
				put_ticks(2);
				put_byte(CHR_P);
				put_byte(REQ_PROG);
			end
			default: begin
				write_regs(65535, RST_COOLDOWN_LONG, RST_COOLDOWN_SHORT, RST_BLOCK_LIMIT,
					RST_FIXED_ADDR_A, RST_FIXED_ADDR_B);
				put_byte(CHR_A);
				put_ticks(1);
				put_byte(CHR_P);
			end
		endcase
		cd = (path == 2) ? 0 : RST_COOLDOWN_LONG;

		// programming commands, in and out of range
		put_byte(CHR_W); put_byte(8'h00); put_byte(8'h00); put_byte(8'hFF);
		put_byte(CHR_W); put_byte(8'h03); put_byte(8'h30); put_byte(8'h11);
		put_byte(CHR_W); put_byte(8'h04); put_byte(8'h00); put_byte(8'h77);
		put_byte(CHR_R); put_byte(8'hFF); put_byte(8'hFF);
		put_byte(CHR_B);
		put_ticks(1);
		put_byte(CHR_X);

		// normal requests, one dropped in cooldown
		put_ticks(cd);
		put_byte(8'd1);
		put_byte(REQ_FIXED_A);
		put_ticks(RST_COOLDOWN_LONG);
		put_byte(8'd0);
		put_byte(RST_BLOCK_LIMIT + 8'd1);
		put_byte(REQ_FIXED_A);
		settle();

		random_regs();
		begin_phase();
		random_items(20);
		settle();

		// no cooldown, widest block range, fixed reads at both ends
		write_regs(0, 0, 0, 255, 1023, 0);
		begin_phase();
		put_byte(8'd253);
		put_byte(REQ_FIXED_A);
		put_byte(REQ_FIXED_B);
		put_byte(8'd1);
		random_items(12);
		settle();

		// longest long cooldown, single block
		write_regs(65535, 255, 2, 1, 1021, 1020);
		begin_phase();
		put_byte(8'd1);
		put_byte(8'd2);
		put_ticks(255);
		put_byte(8'd2);
		put_byte(REQ_FIXED_A);
		settle();

		// receiver holds off while the sender keeps offering
		random_regs();
		tx_calm <= 1'b1;
		hold_arm <= 1'b1;
		@(negedge clk);
		hold_arm <= 1'b0;
		begin_phase();
		random_items(25);
		settle();

		rx_calm <= 1'b1;
		random_regs();
		begin_phase();
		random_items(15);
		settle();
		tx_calm <= 1'b0;
		rx_calm <= 1'b0;

		random_regs();
		begin_phase();
		random_items(15);
		settle();

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

FILE: filelist.f
src/smcr_pkg.sv
src/smcr_store.sv
src/smcr_seq.sv
src/serial_memory_command_responder_unit.sv
verif/tb.sv
